### rtl/deq_pkg.sv
package deq_pkg;

    localparam int DATA_W      = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_DEF   = 32;
    localparam int MAX_RESULTS = 32;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### rtl/deq_store.sv
module deq_store #(
    parameter int DEPTH  = deq_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [deq_pkg::DATA_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [deq_pkg::DATA_W-1:0]  o_rdata
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/double_ended_queue.sv
// Push: result strobed in the cycle after the transfer; busy stays low, one push per cycle.
// Pop and peek, queue not empty: result passes the entry store's read register,
//   then the result register; busy is high in S_READ while that read completes.
// List, queue not empty: the first result takes that path too, then one result per
//   cycle, min(count, 32) results; busy is high while in S_LIST. Results never stall.
// Synchronous active-low reset empties the queue; the entry store is not cleared.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [deq_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [deq_pkg::DATA_W-1:0]    i_value,
    output logic                                 o_strobe,
    output logic [deq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [deq_pkg::DATA_W-1:0]    o_value_res,
    output logic                                 o_last
);
    import deq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LIST
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_lastidx, n_lastidx;
    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_value, n_value;
    logic                r_last, n_last;

    logic                mem_we, mem_re;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;
    logic                accept, full, empty;

    // front + offset, wrapped; both operands stay below DEPTH
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return IW'(sum);
    endfunction

    assign accept = start && !busy;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_idx     = r_idx;
        n_lastidx = r_lastidx;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_value   = '0;
        n_last    = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = r_front;
        mem_re    = 1'b0;
        mem_raddr = r_front;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_value = i_value;
                                n_count = r_count + 1'b1;
                                if (i_kind == KIND_PUSH_FRONT) begin
                                    n_front   = (r_front == '0) ? IW'(DEPTH - 1)
                                                                : r_front - 1'b1;
                                    mem_waddr = n_front;
                                end else begin
                                    mem_waddr = slot(r_front, r_count);
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_READ;
                                if (i_kind == KIND_POP_BACK) begin
                                    mem_raddr = slot(r_front, r_count - 1'b1);
                                    n_count   = r_count - 1'b1;
                                end else if (i_kind == KIND_POP_FRONT) begin
                                    n_front = (r_front == IW'(DEPTH - 1)) ? '0
                                                                          : r_front + 1'b1;
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        KIND_LIST: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_LIST;
                                n_idx   = '0;
                                // cap the listing at the result limit
                                if (32'(r_count) > MAX_RESULTS) begin
                                    n_lastidx = CW'(MAX_RESULTS - 1);
                                end else begin
                                    n_lastidx = r_count - 1'b1;
                                end
                            end
                        end
                        default: begin
                            // unused kinds: drop without a result
                        end
                    endcase
                end
            end
            S_READ: begin
                n_strobe = 1'b1;
                n_value  = mem_rdata;
                n_state  = S_IDLE;
            end
            S_LIST: begin
                n_strobe = 1'b1;
                n_value  = mem_rdata;
                if (r_idx == r_lastidx) begin
                    n_state = S_IDLE;
                end else begin
                    n_last    = 1'b0;
                    n_idx     = r_idx + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_front, n_idx);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx     <= n_idx;
        r_lastidx <= n_lastidx;
        r_status  <= n_status;
        r_value   <= n_value;
        r_last    <= n_last;
    end

    deq_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_res = r_value;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_front) < DEPTH)
        else $error("front index out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_status != ST_OK) |-> (r_value == '0) && r_last)
        else $error("error result carries data or is not last");

    a_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_last |-> (r_state == S_LIST))
        else $error("non-final result outside a list");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_kind == KIND_PUSH_BACK || i_kind == KIND_PUSH_FRONT) && !full
        |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not grow the queue");
`endif

endmodule
